>>> hdl/m4i_pkg.sv
// shared types, constants and helpers for the 4x4 matrix inverse
package m4i_pkg;

  localparam int ELEM_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int NCOL    = 4;
  localparam int ACC_W   = 4 * ELEM_W + 8;
  localparam int PROD_W  = 2 * ELEM_W + 1;
  localparam int QBITS   = ELEM_W + 1;
  localparam int CNT_W   = $clog2(QBITS);

  typedef logic [NCOL*NCOL-1:0][ELEM_W-1:0] mat_t;
  typedef logic [NCOL-1:0][ELEM_W-1:0]      row_t;
  typedef logic signed [ACC_W-1:0]          acc_t;

  typedef struct packed {
    logic start;
    logic div_go;
  } lane_ctl_t;

  typedef struct packed {
    logic part_done;
    logic div_done;
  } lane_stat_t;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL, L_ACC, L_PDONE, L_DSTART, L_DWAIT, L_DONE
  } lane_st_t;

  typedef enum logic [2:0] {
    D_IDLE, D_PREP, D_RUN, D_FIN, D_DONE
  } div_st_t;

  typedef enum logic [2:0] {
    S_LOAD, S_COF, S_SUM, S_ABS, S_DETV, S_DIV, S_OUT
  } top_st_t;

  localparam logic [2:0] OP_A    = 3'd0;
  localparam logic [2:0] OP_B    = 3'd1;
  localparam logic [2:0] OP_C0   = 3'd2;
  localparam logic [2:0] OP_LAST = 3'd4;
  localparam logic [2:0] DET_LAST = 3'd3;

  // k-th index of 0..3 with x left out
  function automatic logic [1:0] skip_idx(input logic [1:0] x, input logic [1:0] k);
    return (k < x) ? k : 2'(k + 2'd1);
  endfunction

  // 32-bit slice of a wide value as a signed multiplier operand
  function automatic logic signed [ELEM_W:0] chunk_op(input acc_t v, input logic [1:0] k,
                                                      input logic top);
    logic [ELEM_W-1:0] w;
    w = v[ELEM_W*k +: ELEM_W];
    return top ? {w[ELEM_W-1], w} : {1'b0, w};
  endfunction

  function automatic logic signed [ELEM_W:0] elem_op(input logic [ELEM_W-1:0] e);
    return {e[ELEM_W-1], e};
  endfunction

endpackage

>>> hdl/matrix4x4_inverse.sv
// top level: row loading, determinant merge, lane control and result rows
//
// A matrix arrives as four input transactions, rows 0 to 3. After the fourth
// row four lanes, one per column, each run their cofactors and a partial
// determinant through a single 32x33 multiplier, with a multiply state (L_MUL)
// and an accumulate state (L_ACC) for each partial product. The merge stage sums
// the four partials, takes the magnitude, then rounds and saturates the
// determinant. Each lane then divides its four cofactors in turn on its own
// restoring divider; a singular matrix skips the divisions. Four result rows
// follow, one per cycle when taken. A new matrix is taken once the last row
// has gone.
module matrix4x4_inverse (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [m4i_pkg::ELEM_W-1:0]  in_elem0,
  input  logic signed [m4i_pkg::ELEM_W-1:0]  in_elem1,
  input  logic signed [m4i_pkg::ELEM_W-1:0]  in_elem2,
  input  logic signed [m4i_pkg::ELEM_W-1:0]  in_elem3,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [m4i_pkg::ELEM_W-1:0]  out_inv0,
  output logic signed [m4i_pkg::ELEM_W-1:0]  out_inv1,
  output logic signed [m4i_pkg::ELEM_W-1:0]  out_inv2,
  output logic signed [m4i_pkg::ELEM_W-1:0]  out_inv3,
  output logic [1:0]                         out_row_index,
  output logic signed [m4i_pkg::ELEM_W-1:0]  out_det_value,
  output logic                               out_singular,
  output logic                               out_last_row
);
  import m4i_pkg::*;

  top_st_t st_r, st_nxt;
  logic [1:0] row_r, orow_r;
  mat_t mat_r;
  acc_t det_r;
  logic [ACC_W-1:0] dmag_r;
  logic dneg_r, sing_r;
  logic [ELEM_W-1:0] detv_r;

  lane_ctl_t  ctl;
  lane_stat_t stat [NCOL];
  acc_t       part [NCOL];
  row_t       lq   [NCOL];

  logic in_acc, out_acc, all_pdone, all_ddone;
  logic [ACC_W-1:0] rm, dlim;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign all_pdone = stat[0].part_done && stat[1].part_done &&
                     stat[2].part_done && stat[3].part_done;
  assign all_ddone = stat[0].div_done && stat[1].div_done &&
                     stat[2].div_done && stat[3].div_done;

  assign ctl.start  = in_acc && (row_r == 2'd3);
  assign ctl.div_go = (st_r == S_DETV) && !sing_r;

  for (genvar gi = 0; gi < NCOL; gi++) begin : g_lane
    m4i_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .lane_id  (2'(gi)),
      .mat      (mat_r),
      .ctl      (ctl),
      .det      (det_r),
      .stat     (stat[gi]),
      .part_det (part[gi]),
      .quot     (lq[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (st_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && row_r == 2'd3) st_nxt = S_COF;
      end
      S_COF: begin
        if (all_pdone) st_nxt = S_SUM;
      end
      S_SUM:  st_nxt = S_ABS;
      S_ABS:  st_nxt = S_DETV;
      S_DETV: st_nxt = sing_r ? S_OUT : S_DIV;
      S_DIV: begin
        if (all_ddone) st_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready && orow_r == 2'd3) st_nxt = S_LOAD;
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_comb begin
    rm   = (dmag_r + (ACC_W'(1) << (3 * FRAC_W - 1))) >> (3 * FRAC_W);
    dlim = dneg_r ? (ACC_W'(1) << (ELEM_W - 1)) : ((ACC_W'(1) << (ELEM_W - 1)) - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      orow_r <= '0;
    end else begin
      if (in_acc) begin
        mat_r[{row_r, 2'd0}] <= in_elem0;
        mat_r[{row_r, 2'd1}] <= in_elem1;
        mat_r[{row_r, 2'd2}] <= in_elem2;
        mat_r[{row_r, 2'd3}] <= in_elem3;
        row_r <= row_r + 1'b1;
      end
      case (st_r)
        S_SUM: det_r <= (part[0] + part[1]) + (part[2] + part[3]);
        S_ABS: begin
          dmag_r <= ACC_W'(det_r[ACC_W-1] ? -det_r : det_r);
          dneg_r <= det_r[ACC_W-1];
          sing_r <= (det_r == '0);
        end
        S_DETV: begin
          orow_r <= '0;
          if (sing_r) detv_r <= '0;
          else if (rm > dlim)
            detv_r <= dneg_r ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
          else detv_r <= dneg_r ? -rm[ELEM_W-1:0] : rm[ELEM_W-1:0];
        end
        S_OUT: begin
          if (out_ready) orow_r <= orow_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_inv0      = sing_r ? '0 : signed'(lq[orow_r][0]);
  assign out_inv1      = sing_r ? '0 : signed'(lq[orow_r][1]);
  assign out_inv2      = sing_r ? '0 : signed'(lq[orow_r][2]);
  assign out_inv3      = sing_r ? '0 : signed'(lq[orow_r][3]);
  assign out_row_index = orow_r;
  assign out_det_value = signed'(detv_r);
  assign out_singular  = sing_r;
  assign out_last_row  = (orow_r == 2'd3);

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_first_row: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_row_index == 2'd0)
    else $error("result rows do not start at row 0");

  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_row |=> in_ready)
    else $error("not ready for next matrix after last row");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_singular |->
      out_inv0 == '0 && out_inv1 == '0 && out_inv2 == '0 && out_inv3 == '0 &&
      out_det_value == '0)
    else $error("singular matrix with nonzero result");
`endif

endmodule

>>> hdl/m4i_div.sv
// iterative rounding divider with saturation to the element range
module m4i_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  m4i_pkg::acc_t               num,
  input  m4i_pkg::acc_t               den,
  output logic                        done,
  output logic [m4i_pkg::ELEM_W-1:0]  quot
);
  import m4i_pkg::*;

  div_st_t st_r, st_nxt;
  logic [ACC_W-1:0]  nmag_r, dmag_r, rem_r;
  logic [QBITS-1:0]  nlo_r, q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              neg_r, ovf_r;
  logic [ELEM_W-1:0] quot_r;

  logic [ACC_W-1:0]  rs;
  logic              ge, rnd, sat;
  logic [QBITS:0]    mag, lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= D_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    done   = 1'b0;
    case (st_r)
      D_IDLE: begin
        if (start) st_nxt = D_PREP;
      end
      D_PREP: st_nxt = D_RUN;
      D_RUN: begin
        if (cnt_r == CNT_W'(QBITS - 1)) st_nxt = D_FIN;
      end
      D_FIN: st_nxt = D_DONE;
      D_DONE: begin
        done   = 1'b1;
        st_nxt = D_IDLE;
      end
      default: st_nxt = D_IDLE;
    endcase
  end

  always_comb begin
    rs  = {rem_r[ACC_W-2:0], nlo_r[QBITS-1]};
    ge  = rs >= dmag_r;
    rnd = {rem_r[ACC_W-2:0], 1'b0} >= dmag_r;
    mag = {1'b0, q_r} + (QBITS+1)'(rnd);
    lim = neg_r ? ((QBITS+1)'(1) << (ELEM_W - 1)) : (((QBITS+1)'(1) << (ELEM_W - 1)) - 1'b1);
    sat = ovf_r || (mag > lim);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      case (st_r)
        D_IDLE: begin
          if (start) begin
            nmag_r <= ACC_W'(num[ACC_W-1] ? -num : num);
            dmag_r <= ACC_W'(den[ACC_W-1] ? -den : den);
            neg_r  <= num[ACC_W-1] ^ den[ACC_W-1];
          end
        end
        D_PREP: begin
          ovf_r <= (nmag_r >> QBITS) >= dmag_r;
          rem_r <= nmag_r >> QBITS;
          nlo_r <= nmag_r[QBITS-1:0];
          q_r   <= '0;
          cnt_r <= '0;
        end
        D_RUN: begin
          rem_r <= ge ? rs - dmag_r : rs;
          q_r   <= {q_r[QBITS-2:0], ge};
          nlo_r <= {nlo_r[QBITS-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
        end
        D_FIN: begin
          if (sat) begin
            quot_r <= neg_r ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
          end else begin
            quot_r <= neg_r ? -mag[ELEM_W-1:0] : mag[ELEM_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign quot = quot_r;

endmodule

>>> hdl/m4i_lane.sv
// one lane: cofactors of one column, partial determinant and four divisions
module m4i_lane (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           lane_id,
  input  m4i_pkg::mat_t        mat,
  input  m4i_pkg::lane_ctl_t   ctl,
  input  m4i_pkg::acc_t        det,
  output m4i_pkg::lane_stat_t  stat,
  output m4i_pkg::acc_t        part_det,
  output m4i_pkg::row_t        quot
);
  import m4i_pkg::*;

  lane_st_t st_r, st_nxt;
  logic [1:0] r_r, t_r, dix_r;
  logic [2:0] op_r;
  logic       det_ph_r;
  logic signed [PROD_W-1:0] prod_r;
  acc_t acc2_r, accm_r, accd_r;
  acc_t cof_r [NCOL];
  row_t q_r;

  logic [1:0] r0, r1, r2, cx, cy, ck, sh;
  logic signed [ELEM_W-1:0] a_sel;
  logic signed [ELEM_W:0]   b_sel;
  logic       neg;
  acc_t       term, term_sh, macc;
  logic       dv_done;
  logic [ELEM_W-1:0] dv_q;

  always_comb begin
    r0 = skip_idx(r_r, 2'd0);
    r1 = skip_idx(r_r, 2'd1);
    r2 = skip_idx(r_r, 2'd2);
    cx = skip_idx(lane_id, (t_r == 2'd0) ? 2'd1 : 2'd0);
    cy = skip_idx(lane_id, (t_r == 2'd2) ? 2'd1 : 2'd2);
    ck = 2'(op_r - OP_C0);
    neg = 1'b0;
    sh  = 2'd0;
    if (det_ph_r) begin
      a_sel = signed'(mat[{2'd0, lane_id}]);
      b_sel = chunk_op(cof_r[0], op_r[1:0], op_r == DET_LAST);
      sh    = op_r[1:0];
    end else begin
      case (op_r)
        OP_A: begin
          a_sel = signed'(mat[{r1, cx}]);
          b_sel = elem_op(mat[{r2, cy}]);
        end
        OP_B: begin
          a_sel = signed'(mat[{r1, cy}]);
          b_sel = elem_op(mat[{r2, cx}]);
        end
        default: begin
          a_sel = signed'(mat[{r0, skip_idx(lane_id, t_r)}]);
          b_sel = chunk_op(acc2_r, ck, ck == 2'd2);
          neg   = (t_r == 2'd1) ^ r_r[0] ^ lane_id[0];
          sh    = ck;
        end
      endcase
    end
    term    = ACC_W'(prod_r);
    term_sh = term << (ELEM_W * sh);
    macc    = accm_r + (neg ? -term_sh : term_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      L_IDLE, L_DONE: begin
        if (ctl.start) st_nxt = L_MUL;
      end
      L_PDONE: begin
        if (ctl.start) st_nxt = L_MUL;
        else if (ctl.div_go) st_nxt = L_DSTART;
      end
      L_MUL: st_nxt = L_ACC;
      L_ACC: begin
        if (det_ph_r && op_r == DET_LAST) st_nxt = L_PDONE;
        else st_nxt = L_MUL;
      end
      L_DSTART: st_nxt = L_DWAIT;
      L_DWAIT: begin
        if (dv_done) st_nxt = (dix_r == 2'd3) ? L_DONE : L_DSTART;
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r      <= '0;
      t_r      <= '0;
      op_r     <= '0;
      det_ph_r <= 1'b0;
      dix_r    <= '0;
    end else begin
      case (st_r)
        L_IDLE, L_PDONE, L_DONE: begin
          if (ctl.start) begin
            r_r      <= '0;
            t_r      <= '0;
            op_r     <= OP_A;
            det_ph_r <= 1'b0;
          end
          dix_r <= '0;
        end
        L_MUL: prod_r <= a_sel * b_sel;
        L_ACC: begin
          if (det_ph_r) begin
            accd_r <= ((op_r == 3'd0) ? '0 : accd_r) + term_sh;
            op_r   <= op_r + 1'b1;
          end else begin
            case (op_r)
              OP_A: begin
                acc2_r <= term;
                if (t_r == 2'd0) accm_r <= '0;
                op_r <= op_r + 1'b1;
              end
              OP_B: begin
                acc2_r <= acc2_r - term;
                op_r   <= op_r + 1'b1;
              end
              default: begin
                accm_r <= macc;
                if (op_r == OP_LAST) begin
                  op_r <= OP_A;
                  if (t_r == 2'd2) begin
                    cof_r[r_r] <= macc;
                    t_r        <= '0;
                    if (r_r == 2'd3) det_ph_r <= 1'b1;
                    else r_r <= r_r + 1'b1;
                  end else begin
                    t_r <= t_r + 1'b1;
                  end
                end else begin
                  op_r <= op_r + 1'b1;
                end
              end
            endcase
          end
        end
        L_DWAIT: begin
          if (dv_done) begin
            q_r[dix_r] <= dv_q;
            dix_r      <= dix_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  m4i_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (st_r == L_DSTART),
    .num   (cof_r[dix_r] << (2 * FRAC_W)),
    .den   (det),
    .done  (dv_done),
    .quot  (dv_q)
  );

  assign stat.part_done = (st_r == L_PDONE);
  assign stat.div_done  = (st_r == L_DONE);
  assign part_det       = accd_r;
  assign quot           = q_r;

endmodule

>>> bench/m4i_checker.sv
// transaction monitor, exact-arithmetic inverse predictor and result checker
`timescale 1ns / 1ps
module m4i_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [m4i_pkg::ELEM_W-1:0] in_elem0,
  input  logic signed [m4i_pkg::ELEM_W-1:0] in_elem1,
  input  logic signed [m4i_pkg::ELEM_W-1:0] in_elem2,
  input  logic signed [m4i_pkg::ELEM_W-1:0] in_elem3,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [m4i_pkg::ELEM_W-1:0] out_inv0,
  input  logic signed [m4i_pkg::ELEM_W-1:0] out_inv1,
  input  logic signed [m4i_pkg::ELEM_W-1:0] out_inv2,
  input  logic signed [m4i_pkg::ELEM_W-1:0] out_inv3,
  input  logic [1:0]                        out_row_index,
  input  logic signed [m4i_pkg::ELEM_W-1:0] out_det_value,
  input  logic                              out_singular,
  input  logic                              out_last_row,
  output int                                fail_count,
  output int                                rows_pending,
  output int                                rows_checked
);
  import m4i_pkg::*;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic signed [ELEM_W-1:0] inv [4];
    logic [1:0]               row;
    logic signed [ELEM_W-1:0] det;
    logic                     sing;
    logic                     last;
  } inv_row_t;

  logic signed [ELEM_W-1:0] held_rows [16];
  logic [1:0]               load_row = 2'd0;
  inv_row_t                 inverse_rows [$];

  initial begin
    fail_count = 0;
    rows_pending = 0;
    rows_checked = 0;
  end

  function automatic wide_t elem(input int r, input int c);
    wide_t w;
    w = held_rows[r*4 + c];
    return w;
  endfunction

  function automatic wide_t cofactor(input int r, input int c);
    int    rs [3];
    int    cs [3];
    int    k;
    int    l;
    wide_t m;
    k = 0;
    l = 0;
    for (int i = 0; i < 4; i++) begin
      if (i != r) begin
        rs[k] = i;
        k++;
      end
      if (i != c) begin
        cs[l] = i;
        l++;
      end
    end
    m = elem(rs[0], cs[0]) * (elem(rs[1], cs[1]) * elem(rs[2], cs[2])
                              - elem(rs[1], cs[2]) * elem(rs[2], cs[1]))
      - elem(rs[0], cs[1]) * (elem(rs[1], cs[0]) * elem(rs[2], cs[2])
                              - elem(rs[1], cs[2]) * elem(rs[2], cs[0]))
      + elem(rs[0], cs[2]) * (elem(rs[1], cs[0]) * elem(rs[2], cs[1])
                              - elem(rs[1], cs[1]) * elem(rs[2], cs[0]));
    return ((r + c) % 2 == 1) ? -m : m;
  endfunction

  // quotient rounded to nearest, ties away from zero
  function automatic wide_t div_round(input wide_t num, input wide_t den);
    wide_t n;
    wide_t d;
    wide_t q;
    wide_t rem;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = n / d;
    rem = n % d;
    if (2 * rem >= d) q = q + 1;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic logic signed [ELEM_W-1:0] clamp_elem(input wide_t v);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (ELEM_W - 1)) - 1;
    lo = -(wide_t'(1) <<< (ELEM_W - 1));
    if (v > hi) return hi[ELEM_W-1:0];
    if (v < lo) return lo[ELEM_W-1:0];
    return v[ELEM_W-1:0];
  endfunction

  task automatic predict_inverse();
    wide_t                    cof [4][4];
    wide_t                    det;
    logic                     sing;
    logic signed [ELEM_W-1:0] detv;
    inv_row_t                 e;
    det = 0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) cof[i][j] = cofactor(i, j);
    for (int j = 0; j < 4; j++) det = det + elem(0, j) * cof[0][j];
    sing = (det == 0);
    detv = sing ? '0 : clamp_elem(div_round(det, wide_t'(1) <<< (3 * FRAC_W)));
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++)
        e.inv[j] = sing ? '0 : clamp_elem(div_round(cof[j][i] <<< (2 * FRAC_W), det));
      e.row = 2'(i);
      e.det = detv;
      e.sing = sing;
      e.last = (i == 3);
      inverse_rows.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    inv_row_t e;
    logic     bad;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        held_rows[load_row*4 + 0] = in_elem0;
        held_rows[load_row*4 + 1] = in_elem1;
        held_rows[load_row*4 + 2] = in_elem2;
        held_rows[load_row*4 + 3] = in_elem3;
        if (load_row == 2'd3) predict_inverse();
        load_row = load_row + 2'd1;
      end
      if (out_valid && out_ready) begin
        if (inverse_rows.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result row %0d at %0t", out_row_index, $realtime);
        end else begin
          e = inverse_rows.pop_front();
          rows_checked++;
          bad = (out_inv0 !== e.inv[0]) || (out_inv1 !== e.inv[1]) ||
                (out_inv2 !== e.inv[2]) || (out_inv3 !== e.inv[3]) ||
                (out_row_index !== e.row) || (out_det_value !== e.det) ||
                (out_singular !== e.sing) || (out_last_row !== e.last);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("ERROR: row mismatch, exp inv %h %h %h %h row %0d det %h sing %b last %b",
                       e.inv[0], e.inv[1], e.inv[2], e.inv[3], e.row, e.det, e.sing, e.last);
              $display("  got inv %h %h %h %h row %0d det %h sing %b last %b",
                       out_inv0, out_inv1, out_inv2, out_inv3, out_row_index,
                       out_det_value, out_singular, out_last_row);
            end
          end
        end
      end
      rows_pending = inverse_rows.size();
    end else begin
      load_row = 2'd0;
      inverse_rows.delete();
      rows_pending = 0;
    end
  end

  final begin
  end
endmodule

>>> bench/tb_matrix4x4_inverse.sv
// top-level testbench: clock, reset, matrix row stimulus and verdict
`timescale 1ns / 1ps
module tb_matrix4x4_inverse;
  import m4i_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [ELEM_W-1:0] E_MAX = 32'sh7fffffff;
  localparam logic signed [ELEM_W-1:0] E_MIN = 32'sh80000000;
  localparam logic signed [ELEM_W-1:0] E_ONE = 32'sh00010000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [ELEM_W-1:0] in_elem0 = '0;
  logic signed [ELEM_W-1:0] in_elem1 = '0;
  logic signed [ELEM_W-1:0] in_elem2 = '0;
  logic signed [ELEM_W-1:0] in_elem3 = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [ELEM_W-1:0] out_inv0, out_inv1, out_inv2, out_inv3, out_det_value;
  logic [1:0]               out_row_index;
  logic                     out_singular, out_last_row;
  int                       fail_count, rows_pending, rows_checked;
  int                       cycles = 0;
  int                       matrices = 0;
  logic                     no_gaps = 1'b0;
  logic signed [ELEM_W-1:0] mat [16];

  matrix4x4_inverse dut (.*);

  m4i_checker u_checker (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_ready <= no_gaps || ($urandom_range(99) >= 22);
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_matrix();
    for (int r = 0; r < 4; r++) begin
      if (!no_gaps && $urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        do @(posedge clk); while ($urandom_range(99) < 40);
      end
      in_valid <= 1'b1;
      in_elem0 <= mat[r*4 + 0];
      in_elem1 <= mat[r*4 + 1];
      in_elem2 <= mat[r*4 + 2];
      in_elem3 <= mat[r*4 + 3];
      do @(posedge clk); while (!in_ready);
    end
    matrices++;
  endtask

  task automatic diag_matrix(input logic signed [ELEM_W-1:0] a, b, c, d);
    for (int i = 0; i < 16; i++) mat[i] = '0;
    mat[0] = a;
    mat[5] = b;
    mat[10] = c;
    mat[15] = d;
  endtask

  function automatic logic signed [ELEM_W-1:0] rand_elem(input int mode);
    case (mode)
      0: return ELEM_W'($urandom_range(32'h7ffff)) - 32'sh40000;
      1: return $urandom;
      2: return ($urandom_range(6) - 3) <<< FRAC_W;
      default: return ($urandom_range(1)) ? $urandom : ELEM_W'($urandom_range(32'h3ffff)) - 32'sh20000;
    endcase
  endfunction

  initial begin
    int mode;
    int src;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    diag_matrix(E_ONE, E_ONE, E_ONE, E_ONE);
    send_matrix();
    diag_matrix('0, '0, '0, '0);
    send_matrix();
    diag_matrix(E_MIN, E_MAX, E_MIN, E_MAX);
    send_matrix();
    diag_matrix(32'sd1, 32'sd1, 32'sd1, 32'sd1);
    send_matrix();
    diag_matrix(-32'sd1, 32'sd1, 32'sd1, 32'sd1);
    send_matrix();
    for (int i = 0; i < 16; i++) mat[i] = $urandom;
    send_matrix();

    for (int m = 0; m < 37; m++) begin
      no_gaps <= (m >= 20 && m < 28);
      if (m == 12) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (rows_pending != 0);
      end
      mode = $urandom_range(9);
      for (int i = 0; i < 16; i++)
        mat[i] = rand_elem(mode < 5 ? 0 : mode < 7 ? 1 : mode == 7 ? 2 : 3);
      if (mode == 8) begin
        src = $urandom_range(3);
        for (int j = 0; j < 4; j++) mat[((src + 1) % 4)*4 + j] = mat[src*4 + j];
      end
      send_matrix();
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (rows_pending != 0);
    repeat (400) @(posedge clk);
    $display("covered %0d matrices (%0d rows): identity, zero, extreme and tiny determinants,",
             matrices, matrices * 4);
    $display("random Q16.16 and full-range values, repeated-row singular cases; %0d rows checked",
             rows_checked);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

>>> matrix4x4_inverse.f
hdl/m4i_pkg.sv
hdl/m4i_div.sv
hdl/m4i_lane.sv
hdl/matrix4x4_inverse.sv
bench/m4i_checker.sv
bench/tb_matrix4x4_inverse.sv
